FILE: sv/lud_pkg.sv
// ----------------------------------------------------------------------------
// lud_pkg
// Shared types, codes and defaults of the LU decomposition unit.
// ----------------------------------------------------------------------------
package lud_pkg;

  localparam int MAX_SIZE_DEF   = 8;
  localparam int DATA_WIDTH_DEF = 32;

  localparam int CFG_W   = 4;
  localparam int OP_W    = 2;
  localparam int IDX_W   = 3;
  localparam int VAL_W   = 32;
  localparam int STAT_W  = 2;
  localparam int FRAC_W  = 16;

  localparam logic [CFG_W-1:0] CFG_SIZE_RESET = 4'd8;

  localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
  localparam logic [OP_W-1:0] OP_DECOMP = 2'd1;
  localparam logic [OP_W-1:0] OP_READ   = 2'd2;
  localparam logic [OP_W-1:0] OP_NONE   = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK         = 2'd0;
  localparam logic [STAT_W-1:0] ST_ZERO_PIVOT = 2'd1;
  localparam logic [STAT_W-1:0] ST_SATURATED  = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PIV_RD,
    S_PIV_CAP,
    S_COL_RD,
    S_COL_DIV,
    S_DIV_WAIT,
    S_COL_WR_L,
    S_COL_WR_U,
    S_UPD_RD,
    S_UPD_MUL,
    S_UPD_WR,
    S_FINISH,
    S_RESP
  } state_t;

  typedef struct packed {
    logic item_start;
    logic load_we;
    logic read_req;
    logic dec_start;
    logic piv_rd;
    logic piv_cap;
    logic col_init;
    logic col_rd;
    logic div_start;
    logic l_wr;
    logic u_wr;
    logic i_inc;
    logic upd_init;
    logic upd_rd;
    logic mul_en;
    logic a_wr;
    logic j_rst;
    logic j_inc;
    logic k_inc;
    logic commit;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic k_end;
    logic i_end;
    logic j_end;
    logic piv_zero;
    logic div_done;
  } sts_t;

endpackage

FILE: sv/lu_decomposition_unit.sv
// ----------------------------------------------------------------------------
// lu_decomposition_unit
// Doolittle LU factorization without pivoting, signed Q16.16.
// ----------------------------------------------------------------------------
//  channel  ports                                        direction
//  in       in_valid/in_ready, operation,row,column,...  request in
//  out      out_valid/out_ready, element, status         request out
//  cfg      cfg_write_en, cfg_write_data (matrix size)   write only
//
//  Load, read (registered memory read) and op 3 go via the response state.
//  Decompose per pivot k, m = n-1-k: pivot read, m divides on the serial
//  divider (none on a zero pivot), then m*m updates on the shared multiplier.
//  No clearing pass after reset; L/U outside the last block read as zero.
//  One request in flight; while a result waits on out_ready the next request
//  is taken but holds in its response state until the result slot frees.
module lu_decomposition_unit #(
  parameter int MAX_SIZE   = lud_pkg::MAX_SIZE_DEF,
  parameter int DATA_WIDTH = lud_pkg::DATA_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_write_en,
  input  logic [lud_pkg::CFG_W-1:0]         cfg_write_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [lud_pkg::OP_W-1:0]          in_operation,
  input  logic [lud_pkg::IDX_W-1:0]         in_row,
  input  logic [lud_pkg::IDX_W-1:0]         in_column,
  input  logic                              in_which_matrix,
  input  logic signed [lud_pkg::VAL_W-1:0]  in_value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [lud_pkg::VAL_W-1:0]  out_element,
  output logic [lud_pkg::STAT_W-1:0]        out_status
);

  lud_pkg::cmd_t cmd;
  lud_pkg::sts_t sts;

  lud_controller u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_operation (in_operation),
    .out_ready    (out_ready),
    .sts          (sts),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .cmd          (cmd)
  );

  lud_datapath #(
    .MAX_SIZE   (MAX_SIZE),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_write_en    (cfg_write_en),
    .cfg_write_data  (cfg_write_data),
    .in_row          (in_row),
    .in_column       (in_column),
    .in_which_matrix (in_which_matrix),
    .in_value        (in_value),
    .cmd             (cmd),
    .sts             (sts),
    .out_element     (out_element),
    .out_status      (out_status)
  );

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request accepted while busy");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status <= lud_pkg::ST_SATURATED))
    else $error("bad status code");

  a_load_once: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> !cmd.out_load)
    else $error("result loaded twice");

endmodule

FILE: sv/lud_divider.sv
// ----------------------------------------------------------------------------
// lud_divider
// Restoring divider, one quotient bit a cycle: (a << 16) / b, truncated
// toward zero and clamped to the stored width.
// ----------------------------------------------------------------------------
module lud_divider #(
  parameter int EFF = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic signed [lud_pkg::VAL_W-1:0] dividend,
  input  logic signed [lud_pkg::VAL_W-1:0] divisor,
  output logic                             done,
  output logic signed [lud_pkg::VAL_W-1:0] quotient,
  output logic                             sat
);

  localparam int W  = lud_pkg::VAL_W;
  localparam int NB = W + lud_pkg::FRAC_W;
  localparam int CNTW = $clog2(NB);
  localparam logic [NB:0] MAG_HI = ((NB+1)'(1) << (EFF - 1)) - (NB+1)'(1);

  logic            busy_r;
  logic            done_r;
  logic            neg_r;
  logic [CNTW-1:0] cnt_r;
  logic [W:0]      rem_r;
  logic [NB-1:0]   quo_r;
  logic [W-1:0]    dmag_r;

  logic [W-1:0] a_mag;
  logic [W-1:0] b_mag;
  logic [W:0]   rem_sh;
  logic         ge;

  assign a_mag  = dividend[W-1] ? (~dividend + W'(1)) : dividend;
  assign b_mag  = divisor[W-1] ? (~divisor + W'(1)) : divisor;
  assign rem_sh = {rem_r[W-1:0], quo_r[NB-1]};
  assign ge     = rem_sh >= {1'b0, dmag_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNTW'(NB - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNTW'(1);
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg_r  <= dividend[W-1] ^ divisor[W-1];
      quo_r  <= {a_mag, {lud_pkg::FRAC_W{1'b0}}};
      dmag_r <= b_mag;
      rem_r  <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? (rem_sh - {1'b0, dmag_r}) : rem_sh;
      quo_r <= {quo_r[NB-2:0], ge};
    end
  end

  logic [W-1:0] hi32;
  assign hi32 = MAG_HI[W-1:0];

  always_comb begin
    sat = 1'b0;
    if (!neg_r && ({1'b0, quo_r} > MAG_HI)) begin
      sat      = 1'b1;
      quotient = hi32;
    end else if (neg_r && ({1'b0, quo_r} > (MAG_HI + (NB+1)'(1)))) begin
      sat      = 1'b1;
      quotient = ~hi32;
    end else if (neg_r) begin
      quotient = ~quo_r[W-1:0] + W'(1);
    end else begin
      quotient = quo_r[W-1:0];
    end
  end

  assign done = done_r;

endmodule

FILE: sv/lud_datapath.sv
// ----------------------------------------------------------------------------
// lud_datapath
// Matrix stores, index counters, multiply-subtract and result register.
// ----------------------------------------------------------------------------
module lud_datapath #(
  parameter int MAX_SIZE   = lud_pkg::MAX_SIZE_DEF,
  parameter int DATA_WIDTH = lud_pkg::DATA_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_write_en,
  input  logic [lud_pkg::CFG_W-1:0]         cfg_write_data,
  input  logic [lud_pkg::IDX_W-1:0]         in_row,
  input  logic [lud_pkg::IDX_W-1:0]         in_column,
  input  logic                              in_which_matrix,
  input  logic signed [lud_pkg::VAL_W-1:0]  in_value,
  input  lud_pkg::cmd_t                     cmd,
  output lud_pkg::sts_t                     sts,
  output logic signed [lud_pkg::VAL_W-1:0]  out_element,
  output logic [lud_pkg::STAT_W-1:0]        out_status
);

  localparam int W     = lud_pkg::VAL_W;
  localparam int EFF   = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;
  localparam int DEPTH = MAX_SIZE * MAX_SIZE;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(MAX_SIZE + 1);
  localparam logic signed [63:0] SAT_HI = (64'sd1 <<< (EFF - 1)) - 64'sd1;
  localparam logic signed [63:0] SAT_LO = -SAT_HI - 64'sd1;
  localparam logic ONE_SAT = (EFF <= 17);
  localparam logic signed [W-1:0] ONE_Q = ONE_SAT ? W'(SAT_HI) : W'(65536);

  function automatic logic [AW-1:0] addr_of(input int r, input int c);
    addr_of = AW'(r * MAX_SIZE + c);
  endfunction

  function automatic logic over(input logic signed [63:0] x);
    over = (x > SAT_HI) || (x < SAT_LO);
  endfunction

  function automatic logic signed [W-1:0] clamp(input logic signed [63:0] x);
    if (x > SAT_HI)      clamp = W'(SAT_HI);
    else if (x < SAT_LO) clamp = W'(SAT_LO);
    else                 clamp = x[W-1:0];
  endfunction

  logic signed [W-1:0] work_mem [DEPTH];
  logic signed [W-1:0] scr_mem  [DEPTH];
  logic signed [W-1:0] l_mem    [DEPTH];
  logic signed [W-1:0] u_mem    [DEPTH];

  logic [lud_pkg::CFG_W-1:0] size_r;
  logic [CW-1:0] n_r, k_r, i_r, j_r, last_n_r;
  logic signed [W-1:0] piv_r, work_q_r, scr_q_r, l_q_r, u_q_r;
  logic signed [63:0]  prod_r;
  logic a_src_r, zp_r, sat_r;
  logic [lud_pkg::STAT_W-1:0] err_r;
  logic rd_ok_r, rd_which_r, rd_diag_r, rd_above_r;
  logic signed [W-1:0] element_r;
  logic [lud_pkg::STAT_W-1:0] status_r;

  int ki, ii, ji, ri, ci;
  assign ki = int'(k_r);
  assign ii = int'(i_r);
  assign ji = int'(j_r);
  assign ri = int'(in_row);
  assign ci = int'(in_column);

  logic signed [W-1:0] a_q, div_q, l_val;
  logic signed [63:0]  upd_diff;
  logic                div_done, div_sat, a_re, l_re, u_re, in_range;
  logic [AW-1:0]       a_addr, l_raddr, u_raddr, u_waddr, in_addr;
  logic [CW-1:0]       n_new;

  assign a_q      = a_src_r ? work_q_r : scr_q_r;
  assign in_range = (ri < MAX_SIZE) && (ci < MAX_SIZE);
  assign in_addr  = addr_of(ri, ci);
  assign l_val    = (piv_r == '0) ? '0 : div_q;
  assign upd_diff = 64'(a_q) - (prod_r >>> lud_pkg::FRAC_W);

  assign sts.k_end    = (ki + 1 == int'(n_r));
  assign sts.i_end    = (ii + 1 == int'(n_r));
  assign sts.j_end    = (ji + 1 == int'(n_r));
  assign sts.piv_zero = (piv_r == '0);
  assign sts.div_done = div_done;

  always_comb begin
    a_re = cmd.piv_rd | cmd.col_rd | cmd.l_wr | cmd.upd_rd;
    if (cmd.piv_rd)      a_addr = addr_of(ki, ki);
    else if (cmd.col_rd) a_addr = addr_of(ii, ki);
    else if (cmd.l_wr)   a_addr = addr_of(ki, ii);
    else                 a_addr = addr_of(ii, ji);
    l_re    = cmd.read_req | cmd.upd_rd;
    u_re    = l_re;
    l_raddr = cmd.read_req ? in_addr : addr_of(ii, ki);
    u_raddr = cmd.read_req ? in_addr : addr_of(ki, ji);
    u_waddr = cmd.piv_cap ? addr_of(ki, ki) : addr_of(ki, ii);
    if (size_r == '0)                   n_new = CW'(1);
    else if (int'(size_r) > MAX_SIZE)   n_new = CW'(MAX_SIZE);
    else                                n_new = CW'(size_r);
  end

  lud_divider #(.EFF(EFF)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (a_q),
    .divisor  (piv_r),
    .done     (div_done),
    .quotient (div_q),
    .sat      (div_sat)
  );

  always_ff @(posedge clk) begin
    if (cmd.load_we && in_range) work_mem[in_addr] <= clamp(64'(in_value));
    if (cmd.a_wr) scr_mem[addr_of(ii, ji)] <= clamp(upd_diff);
    if (a_re) begin
      work_q_r <= work_mem[a_addr];
      scr_q_r  <= scr_mem[a_addr];
      a_src_r  <= (k_r == '0);
    end
    if (cmd.l_wr) l_mem[addr_of(ii, ki)] <= l_val;
    if (l_re) l_q_r <= l_mem[l_raddr];
    if (cmd.piv_cap || cmd.u_wr) u_mem[u_waddr] <= a_q;
    if (u_re) u_q_r <= u_mem[u_raddr];
    if (cmd.piv_cap) piv_r <= a_q;
    if (cmd.mul_en) prod_r <= 64'(l_q_r) * 64'(u_q_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r   <= lud_pkg::CFG_SIZE_RESET;
      n_r      <= '0;
      k_r      <= '0;
      i_r      <= '0;
      j_r      <= '0;
      last_n_r <= '0;
      zp_r     <= 1'b0;
      sat_r    <= 1'b0;
      err_r    <= lud_pkg::ST_OK;
      rd_ok_r  <= 1'b0;
    end else begin
      if (cfg_write_en) size_r <= cfg_write_data;
      if (cmd.dec_start) begin
        n_r   <= n_new;
        k_r   <= '0;
        zp_r  <= 1'b0;
        sat_r <= ONE_SAT;
      end
      if (cmd.col_init || cmd.upd_init) i_r <= k_r + CW'(1);
      if (cmd.i_inc) i_r <= i_r + CW'(1);
      if (cmd.upd_init || cmd.j_rst) j_r <= k_r + CW'(1);
      if (cmd.j_inc) j_r <= j_r + CW'(1);
      if (cmd.k_inc) k_r <= k_r + CW'(1);
      if (cmd.l_wr) begin
        if (piv_r == '0) zp_r  <= 1'b1;
        else if (div_sat) sat_r <= 1'b1;
      end
      if (cmd.a_wr && over(upd_diff)) sat_r <= 1'b1;
      if (cmd.commit) begin
        last_n_r <= n_r;
        err_r    <= zp_r ? lud_pkg::ST_ZERO_PIVOT
                         : (sat_r ? lud_pkg::ST_SATURATED : lud_pkg::ST_OK);
      end
      if (cmd.item_start)
        rd_ok_r <= cmd.read_req && in_range && (ri < int'(last_n_r))
                   && (ci < int'(last_n_r));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.item_start) begin
      rd_which_r <= in_which_matrix;
      rd_diag_r  <= (in_row == in_column);
      rd_above_r <= (in_column > in_row);
    end
    if (cmd.out_load) begin
      status_r <= err_r;
      if (!rd_ok_r)                     element_r <= '0;
      else if (rd_which_r)              element_r <= (rd_diag_r || rd_above_r) ? u_q_r : '0;
      else if (rd_diag_r)               element_r <= ONE_Q;
      else if (rd_above_r)              element_r <= '0;
      else                              element_r <= l_q_r;
    end
  end

  assign out_element = element_r;
  assign out_status  = status_r;

endmodule

FILE: sv/lud_controller.sv
// ----------------------------------------------------------------------------
// lud_controller
// Sequencer for load, read and the pivot / column / update loops.
// ----------------------------------------------------------------------------
module lud_controller (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic [lud_pkg::OP_W-1:0]    in_operation,
  input  logic                        out_ready,
  input  lud_pkg::sts_t               sts,
  output logic                        in_ready,
  output logic                        out_valid,
  output lud_pkg::cmd_t               cmd
);

  lud_pkg::state_t state_r, state_nxt;
  logic out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lud_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cmd.out_load)     out_valid_r <= 1'b1;
      else if (out_ready)   out_valid_r <= 1'b0;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      lud_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.item_start = 1'b1;
          state_nxt      = lud_pkg::S_RESP;
          case (in_operation)
            lud_pkg::OP_LOAD:   cmd.load_we = 1'b1;
            lud_pkg::OP_READ:   cmd.read_req = 1'b1;
            lud_pkg::OP_DECOMP: begin
              cmd.dec_start = 1'b1;
              state_nxt     = lud_pkg::S_PIV_RD;
            end
            default: ;
          endcase
        end
      end
      lud_pkg::S_PIV_RD: begin
        cmd.piv_rd = 1'b1;
        state_nxt  = lud_pkg::S_PIV_CAP;
      end
      lud_pkg::S_PIV_CAP: begin
        cmd.piv_cap = 1'b1;
        if (sts.k_end) begin
          state_nxt = lud_pkg::S_FINISH;
        end else begin
          cmd.col_init = 1'b1;
          state_nxt    = lud_pkg::S_COL_RD;
        end
      end
      lud_pkg::S_COL_RD: begin
        cmd.col_rd = 1'b1;
        state_nxt  = lud_pkg::S_COL_DIV;
      end
      lud_pkg::S_COL_DIV: begin
        if (sts.piv_zero) begin
          state_nxt = lud_pkg::S_COL_WR_L;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = lud_pkg::S_DIV_WAIT;
        end
      end
      lud_pkg::S_DIV_WAIT: begin
        if (sts.div_done) state_nxt = lud_pkg::S_COL_WR_L;
      end
      lud_pkg::S_COL_WR_L: begin
        cmd.l_wr  = 1'b1;
        state_nxt = lud_pkg::S_COL_WR_U;
      end
      lud_pkg::S_COL_WR_U: begin
        cmd.u_wr = 1'b1;
        if (sts.i_end) begin
          cmd.upd_init = 1'b1;
          state_nxt    = lud_pkg::S_UPD_RD;
        end else begin
          cmd.i_inc = 1'b1;
          state_nxt = lud_pkg::S_COL_RD;
        end
      end
      lud_pkg::S_UPD_RD: begin
        cmd.upd_rd = 1'b1;
        state_nxt  = lud_pkg::S_UPD_MUL;
      end
      lud_pkg::S_UPD_MUL: begin
        cmd.mul_en = 1'b1;
        state_nxt  = lud_pkg::S_UPD_WR;
      end
      lud_pkg::S_UPD_WR: begin
        cmd.a_wr  = 1'b1;
        state_nxt = lud_pkg::S_UPD_RD;
        if (!sts.j_end) begin
          cmd.j_inc = 1'b1;
        end else if (!sts.i_end) begin
          cmd.j_rst = 1'b1;
          cmd.i_inc = 1'b1;
        end else begin
          cmd.k_inc = 1'b1;
          state_nxt = lud_pkg::S_PIV_RD;
        end
      end
      lud_pkg::S_FINISH: begin
        cmd.commit = 1'b1;
        state_nxt  = lud_pkg::S_RESP;
      end
      lud_pkg::S_RESP: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = lud_pkg::S_IDLE;
        end
      end
      default: state_nxt = lud_pkg::S_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

FILE: tb/sv/lud_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lud_checker
// Watches the request and result channels of the LU decomposition unit,
// keeps its own copy of the work, L and U matrices and the size register,
// predicts each result and compares it field by field.
// ----------------------------------------------------------------------------
module lud_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_write_en,
  input  logic [lud_pkg::CFG_W-1:0]         cfg_write_data,
  input  logic                              in_valid,
  input  logic                              in_ready,
  input  logic [lud_pkg::OP_W-1:0]          in_operation,
  input  logic [lud_pkg::IDX_W-1:0]         in_row,
  input  logic [lud_pkg::IDX_W-1:0]         in_column,
  input  logic                              in_which_matrix,
  input  logic signed [lud_pkg::VAL_W-1:0]  in_value,
  input  logic                              out_valid,
  input  logic                              out_ready,
  input  logic signed [lud_pkg::VAL_W-1:0]  out_element,
  input  logic [lud_pkg::STAT_W-1:0]        out_status,
  output int                                fail_count,
  output int                                pending_count
);

  localparam int N = lud_pkg::MAX_SIZE_DEF;
  localparam longint HI = 64'sd2147483647;
  localparam longint LO = -64'sd2147483648;

  typedef struct packed {
    logic signed [lud_pkg::VAL_W-1:0] element;
    logic [lud_pkg::STAT_W-1:0]       status;
  } lud_result_t;

  logic signed [lud_pkg::VAL_W-1:0] work_m [N][N];
  logic signed [lud_pkg::VAL_W-1:0] low_m [N][N];
  logic signed [lud_pkg::VAL_W-1:0] up_m [N][N];
  logic [lud_pkg::STAT_W-1:0] err_st;
  logic [lud_pkg::CFG_W-1:0] size_reg;
  lud_result_t expected_results[$];

  assign pending_count = expected_results.size();

  function automatic logic signed [lud_pkg::VAL_W-1:0] sat32(longint x, ref bit sat);
    if (x > HI) begin
      sat = 1;
      return HI[31:0];
    end
    if (x < LO) begin
      sat = 1;
      return LO[31:0];
    end
    return x[31:0];
  endfunction

  function automatic longint qmul(longint x, longint y);
    longint p;
    p = x * y;
    return p >>> 16;
  endfunction

  task automatic factor();
    logic signed [lud_pkg::VAL_W-1:0] a [N][N];
    int n;
    bit zp, sat;
    logic signed [lud_pkg::VAL_W-1:0] piv;
    longint num;
    zp = 0;
    sat = 0;
    n = size_reg;
    if (n < 1) n = 1;
    if (n > N) n = N;
    for (int i = 0; i < N; i++)
      for (int j = 0; j < N; j++) begin
        a[i][j] = work_m[i][j];
        low_m[i][j] = '0;
        up_m[i][j] = '0;
      end
    for (int i = 0; i < n; i++) low_m[i][i] = 32'sh0001_0000;
    for (int k = 0; k < n; k++) begin
      piv = a[k][k];
      up_m[k][k] = piv;
      for (int i = k + 1; i < n; i++) begin
        if (piv == 0) begin
          low_m[i][k] = '0;
          zp = 1;
        end else begin
          num = longint'(a[i][k]) * 65536;
          low_m[i][k] = sat32(num / longint'(piv), sat);
        end
        up_m[k][i] = a[k][i];
      end
      for (int i = k + 1; i < n; i++)
        for (int j = k + 1; j < n; j++)
          a[i][j] = sat32(longint'(a[i][j]) - qmul(low_m[i][k], up_m[k][j]), sat);
    end
    err_st = zp ? lud_pkg::ST_ZERO_PIVOT
                : (sat ? lud_pkg::ST_SATURATED : lud_pkg::ST_OK);
  endtask

  always @(posedge clk) begin
    lud_result_t r, got;
    if (!rst_n) begin
      for (int i = 0; i < N; i++)
        for (int j = 0; j < N; j++) begin
          work_m[i][j] = '0;
          low_m[i][j] = '0;
          up_m[i][j] = '0;
        end
      err_st = lud_pkg::ST_OK;
      size_reg = lud_pkg::CFG_SIZE_RESET;
      fail_count = 0;
      expected_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        got.element = out_element;
        got.status = out_status;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result element=%h status=%0d", $time,
                   out_element, out_status);
          fail_count++;
        end else begin
          r = expected_results.pop_front();
          if (got.element !== r.element) begin
            $display("%0t: element expected %h actual %h", $time, r.element,
                     got.element);
            fail_count++;
          end
          if (got.status !== r.status) begin
            $display("%0t: status expected %0d actual %0d", $time, r.status,
                     got.status);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        r.element = '0;
        case (in_operation)
          lud_pkg::OP_LOAD: work_m[in_row][in_column] = in_value;
          lud_pkg::OP_DECOMP: factor();
          lud_pkg::OP_READ: r.element = in_which_matrix ? up_m[in_row][in_column]
                                                        : low_m[in_row][in_column];
          default: ;
        endcase
        r.status = err_st;
        expected_results.push_back(r);
      end
      if (cfg_write_en) size_reg = cfg_write_data;
    end
  end
endmodule

FILE: tb/sv/lu_decomposition_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lu_decomposition_unit_test
// Drives loads, decompositions and reads into the LU decomposition unit at
// several matrix sizes with random gaps and result stalls; the checker
// predicts and compares every result.
// ----------------------------------------------------------------------------
module lu_decomposition_unit_test;

  localparam longint CYCLE_LIMIT = 3000000;

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_write_en = 0;
  logic [lud_pkg::CFG_W-1:0] cfg_write_data = '0;
  logic in_valid = 0;
  logic in_ready;
  logic [lud_pkg::OP_W-1:0] in_operation = '0;
  logic [lud_pkg::IDX_W-1:0] in_row = '0;
  logic [lud_pkg::IDX_W-1:0] in_column = '0;
  logic in_which_matrix = 0;
  logic signed [lud_pkg::VAL_W-1:0] in_value = '0;
  logic out_valid;
  logic out_ready = 0;
  logic signed [lud_pkg::VAL_W-1:0] out_element;
  logic [lud_pkg::STAT_W-1:0] out_status;
  int fail_count, pending_count;
  longint cycles = 0;
  bit hold_off = 0;
  bit quiet_out = 0;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  lu_decomposition_unit dut (.*);
  lud_checker chk (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 93) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  // result side: random stalls, or a long hold when asked
  always @(posedge clk) begin
    if (!rst_n || hold_off) out_ready <= 0;
    else if (quiet_out) out_ready <= 1;
    else out_ready <= ($urandom_range(0, 99) < 70);
  end

  // valid stays up between back-to-back requests; dropped only for a gap or a drain
  task automatic send(logic [lud_pkg::OP_W-1:0] op, int r, int c, int w,
                      logic [31:0] v);
    int g;
    g = quiet_out ? 0 : gap_len();
    if (g > 0) begin
      in_valid <= 0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1;
    in_operation <= op;
    in_row <= lud_pkg::IDX_W'(r);
    in_column <= lud_pkg::IDX_W'(c);
    in_which_matrix <= w[0];
    in_value <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    @(negedge clk);
    while (pending_count != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic set_size(int n);
    drain();
    cfg_write_en <= 1;
    cfg_write_data <= lud_pkg::CFG_W'(n);
    @(posedge clk);
    cfg_write_en <= 0;
  endtask

  function automatic logic [31:0] rand_val();
    int p;
    p = $urandom_range(0, 9);
    if (p < 5) return $signed($urandom_range(0, 32'h3_0000)) - 32'sh1_8000;
    if (p < 7) return $urandom;
    if (p == 7) return 32'h7fff_ffff;
    if (p == 8) return 32'h8000_0000;
    return 0;
  endfunction

  // full 8x8 load so no unwritten entry is ever used
  task automatic load_all(bit diag_strong);
    for (int r = 0; r < 8; r++)
      for (int c = 0; c < 8; c++)
        send(lud_pkg::OP_LOAD, r, c, $urandom_range(0, 1),
             (diag_strong && r == c) ? 32'h0008_0000 : rand_val());
  endtask

  task automatic read_some(int cnt);
    for (int i = 0; i < cnt; i++)
      send(lud_pkg::OP_READ, $urandom_range(0, 7), $urandom_range(0, 7),
           $urandom_range(0, 1), $urandom);
  endtask

  int sent;

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // directed: extremes, zero pivot, op 3, sizes 1, 15 and 0
    load_all(0);
    send(lud_pkg::OP_LOAD, 0, 0, 0, 32'h7fff_ffff);
    send(lud_pkg::OP_LOAD, 1, 1, 1, 32'h8000_0000);
    send(lud_pkg::OP_LOAD, 0, 1, 0, 32'h0000_0000);
    send(lud_pkg::OP_DECOMP, 7, 7, 1, 32'hffff_ffff);
    send(lud_pkg::OP_READ, 7, 7, 1, 0);
    send(lud_pkg::OP_READ, 1, 0, 0, 0);
    send(lud_pkg::OP_NONE, 5, 2, 1, 32'h1234_5678);
    send(lud_pkg::OP_LOAD, 0, 0, 0, 0);
    send(lud_pkg::OP_DECOMP, 0, 0, 0, 0);
    send(lud_pkg::OP_READ, 3, 0, 0, 0);
    set_size(1);
    send(lud_pkg::OP_DECOMP, 0, 0, 0, 0);
    send(lud_pkg::OP_READ, 0, 0, 1, 0);
    send(lud_pkg::OP_READ, 0, 0, 0, 0);
    set_size(15);
    send(lud_pkg::OP_DECOMP, 0, 0, 0, 0);
    send(lud_pkg::OP_READ, 7, 6, 0, 0);
    set_size(0);
    send(lud_pkg::OP_DECOMP, 0, 0, 0, 0);
    send(lud_pkg::OP_READ, 0, 0, 1, 0);
    // pressure: long hold with the sender still offering
    fork
      begin
        hold_off = 1;
        repeat (400) @(posedge clk);
        hold_off = 0;
      end
      read_some(10);
    join
    drain();
    // paused sender: every result back, then a burst with no gaps
    quiet_out = 1;
    read_some(12);
    quiet_out = 0;
    sent = 0;
    while (sent < 1300) begin
      set_size($urandom_range(0, 9) < 7 ? $urandom_range(1, 4) : $urandom_range(5, 8));
      load_all($urandom_range(0, 1));
      sent += 64;
      for (int d = 0; d < 2; d++) begin
        for (int i = 0; i < 3; i++)
          send(lud_pkg::OP_LOAD, $urandom_range(0, 7), $urandom_range(0, 7), 0,
               rand_val());
        send(lud_pkg::OP_DECOMP, $urandom_range(0, 7), $urandom_range(0, 7),
             $urandom_range(0, 1), $urandom);
        read_some(12);
        send($urandom_range(0, 1) ? lud_pkg::OP_NONE : lud_pkg::OP_READ, 0, 0, 0,
             $urandom);
        sent += 17;
      end
    end
    drain();
    if (fail_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end
endmodule
